// ===== hw/rtl/rdr_pkg.sv =====
// shared types, codes and constants of the radix digit entry register
package rdr_pkg;

  localparam int VALUE_W  = 16;
  localparam int DIGITS   = 5;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int PROD_W   = VALUE_W + 4;
  localparam int COUNT_W  = $clog2(VALUE_W + 1);

  localparam logic [VALUE_W-1:0] VALUE_MAX  = 16'hffff;
  localparam logic [VALUE_W-1:0] CHAR_LIMIT = 16'h0100;
  // x / 10 == (x * 0xcccd) >> 19 for every 16-bit x
  localparam logic [VALUE_W-1:0] DIV10_RECIP = 16'hcccd;
  localparam int                 DIV10_SHIFT = 19;

  // operation codes
  localparam logic [2:0] MODE_DIGIT     = 3'd0;
  localparam logic [2:0] MODE_CLEAR     = 3'd1;
  localparam logic [2:0] MODE_BACKSPACE = 3'd2;
  localparam logic [2:0] MODE_INC       = 3'd3;
  localparam logic [2:0] MODE_DEC       = 3'd4;

  // radix select codes
  localparam logic [1:0] RADIX_HEX = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_BIN = 2'd3;

  typedef struct packed {
    logic [2:0] ten_thousands;
    logic [3:0] thousands;
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } rdr_digits_t;

  function automatic logic [4:0] radix_value(input logic [1:0] sel);
    logic [4:0] r;
    case (sel)
      RADIX_HEX: r = 5'd16;
      RADIX_DEC: r = 5'd10;
      RADIX_OCT: r = 5'd8;
      RADIX_BIN: r = 5'd2;
      default:   r = 5'd10;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/rdr_next_value.sv =====
// next entry value and reject flag for one keypad operation
module rdr_next_value (
  input  logic [rdr_pkg::VALUE_W-1:0] value,
  input  logic [2:0]                  mode,
  input  logic [3:0]                  digit,
  input  logic [1:0]                  radix_sel,
  output logic [rdr_pkg::VALUE_W-1:0] next_value,
  output logic                        rejected
);

  logic [rdr_pkg::PROD_W-1:0]    v_ext;
  logic [rdr_pkg::PROD_W-1:0]    shifted;
  logic [rdr_pkg::PROD_W-1:0]    prod;
  logic [2*rdr_pkg::VALUE_W-1:0] recip_prod;
  logic [rdr_pkg::VALUE_W-1:0]   quot;
  logic [4:0]                    radix;

  assign v_ext = {4'b0, value};
  assign radix = rdr_pkg::radix_value(radix_sel);
  assign recip_prod = value * rdr_pkg::DIV10_RECIP;

  always_comb begin
    case (radix_sel)
      rdr_pkg::RADIX_HEX: begin
        shifted = v_ext << 4;
        quot    = value >> 4;
      end
      rdr_pkg::RADIX_DEC: begin
        shifted = (v_ext << 3) + (v_ext << 1);
        quot    = rdr_pkg::VALUE_W'(recip_prod >> rdr_pkg::DIV10_SHIFT);
      end
      rdr_pkg::RADIX_OCT: begin
        shifted = v_ext << 3;
        quot    = value >> 3;
      end
      rdr_pkg::RADIX_BIN: begin
        shifted = v_ext << 1;
        quot    = value >> 1;
      end
      default: begin
        shifted = v_ext;
        quot    = value;
      end
    endcase
  end

  assign prod = shifted + {{(rdr_pkg::PROD_W-4){1'b0}}, digit};

  always_comb begin
    next_value = value;
    rejected   = 1'b0;
    case (mode)
      rdr_pkg::MODE_DIGIT: begin
        // refused when digit is out of radix or the shift overflows
        if ({1'b0, digit} >= radix ||
            prod[rdr_pkg::PROD_W-1:rdr_pkg::VALUE_W] != '0) begin
          rejected = 1'b1;
        end else begin
          next_value = prod[rdr_pkg::VALUE_W-1:0];
        end
      end
      rdr_pkg::MODE_CLEAR:     next_value = '0;
      rdr_pkg::MODE_BACKSPACE: next_value = quot;
      rdr_pkg::MODE_INC: begin
        if (value != rdr_pkg::VALUE_MAX) next_value = value + 1'b1;
      end
      rdr_pkg::MODE_DEC: begin
        if (value != '0) next_value = value - 1'b1;
      end
      default: next_value = value;
    endcase
  end

endmodule

// ===== hw/rtl/rdr_bcd_conv.sv =====
// iterative binary to decimal converter, one shift-and-correct step a cycle
module rdr_bcd_conv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rdr_pkg::VALUE_W-1:0] value,
  output logic                        done,
  output rdr_pkg::rdr_digits_t        digits
);

  logic [rdr_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [rdr_pkg::BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [rdr_pkg::BCD_W-1:0]   bcd_adj;
  logic [rdr_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < rdr_pkg::DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      else                         bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    count_nxt = count_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      bin_nxt   = value;
      bcd_nxt   = '0;
      count_nxt = rdr_pkg::COUNT_W'(rdr_pkg::VALUE_W);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      {bcd_nxt, bin_nxt} = {bcd_adj[rdr_pkg::BCD_W-2:0], bin_r, 1'b0};
      count_nxt = count_r - 1'b1;
      if (count_r == rdr_pkg::COUNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done   = done_r;
  // ten thousands digit never exceeds 6, so its top bit is dropped
  assign digits = rdr_pkg::rdr_digits_t'(bcd_r[rdr_pkg::BCD_W-2:0]);

endmodule

// ===== hw/rtl/radix_digit_entry_register_unit.sv =====
// top level of the radix digit entry register
//
// Keypad entry register: holds a 16-bit value edited one operation per
// input transfer (digit, clear, backspace, increment, decrement) in the
// radix held by the cfg register (hex, decimal, octal, binary).
// Input channel in_valid/in_ready carries in_mode and in_digit; every
// accepted transfer gives exactly one result on out_valid/out_ready with
// the new value, its five decimal digits and status flags.
// cfg_wr_en writes cfg_wr_data into the radix register at once; write it
// only while no operation is in flight.
// An input transfer is worked in order: update the value and start the
// converter, 16 steps of the shared shift-and-add-3 unit, see the
// converter finish, load the result. One operation is in flight at a
// time, so the next input transfer is taken only once the result is
// loaded, which may wait on out_ready. in_ready is low while an item is
// being worked.
// A stalled receiver holds the result register; a finished conversion
// waits until that register is free, so nothing is dropped.
// Reset (rst_n low, synchronous) clears the value to zero, sets the
// radix to decimal and empties the result register.
module radix_digit_entry_register_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_digit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_current_value,
  output logic [2:0]  out_ten_thousands,
  output logic [3:0]  out_thousands,
  output logic [3:0]  out_hundreds,
  output logic [3:0]  out_tens,
  output logic [3:0]  out_ones,
  output logic        out_at_zero,
  output logic        out_at_max,
  output logic        out_entry_rejected,
  output logic        out_char_valid
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CONV,
    ST_OUT
  } state_t;

  state_t                       state_r;
  logic [1:0]                   radix_r;
  logic [2:0]                   mode_r;
  logic [3:0]                   digit_r;
  logic [rdr_pkg::VALUE_W-1:0]  value_r;
  logic                         rejected_r;
  logic [rdr_pkg::VALUE_W-1:0]  next_value;
  logic                         next_rejected;
  logic                         conv_start;
  logic                         conv_done;
  rdr_pkg::rdr_digits_t         digits;
  logic                         out_free;

  rdr_next_value u_next (
    .value      (value_r),
    .mode       (mode_r),
    .digit      (digit_r),
    .radix_sel  (radix_r),
    .next_value (next_value),
    .rejected   (next_rejected)
  );

  rdr_bcd_conv u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .value  (next_value),
    .done   (conv_done),
    .digits (digits)
  );

  assign in_ready   = (state_r == ST_IDLE);
  assign conv_start = (state_r == ST_UPDATE);
  assign out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      radix_r   <= rdr_pkg::RADIX_DEC;
      value_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) radix_r <= cfg_wr_data;
      if (out_valid && out_ready && state_r != ST_OUT) out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          // converter loads the new value at this same edge
          value_r    <= next_value;
          rejected_r <= next_rejected;
          state_r    <= ST_CONV;
        end
        ST_CONV: begin
          if (conv_done) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_current_value  <= value_r;
            out_ten_thousands  <= digits.ten_thousands;
            out_thousands      <= digits.thousands;
            out_hundreds       <= digits.hundreds;
            out_tens           <= digits.tens;
            out_ones           <= digits.ones;
            out_at_zero        <= (value_r == '0);
            out_at_max         <= (value_r == rdr_pkg::VALUE_MAX);
            out_entry_rejected <= rejected_r;
            out_char_valid     <= (value_r < rdr_pkg::CHAR_LIMIT);
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
    if (in_valid && in_ready) begin
      mode_r  <= in_mode;
      digit_r <= in_digit;
    end
  end

endmodule

// ===== dv/tb_radix_digit_entry_register_unit.sv =====
// testbench for the radix digit entry register: directed table, random keypad traffic, scoreboard
module tb_radix_digit_entry_register_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // mode codes with no operation behind them
  localparam logic [2:0] MODE_SPARE_5 = 3'd5;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam int ITEMS_PER_PHASE = 460;
  localparam int PRINT_LIMIT     = 40;

  typedef struct packed {
    logic [15:0]          value;
    rdr_pkg::rdr_digits_t digits;
    logic                 at_zero;
    logic                 at_max;
    logic                 rejected;
    logic                 char_valid;
  } entry_result_t;

  typedef struct packed {
    bit          cfg_row;
    logic [1:0]  radix;
    logic [2:0]  mode;
    logic [3:0]  digit;
    bit          typed;
    logic [15:0] value;
    logic        rejected;
  } keypad_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_mode = '0;
  logic [3:0]  in_digit = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_current_value;
  logic [2:0]  out_ten_thousands;
  logic [3:0]  out_thousands;
  logic [3:0]  out_hundreds;
  logic [3:0]  out_tens;
  logic [3:0]  out_ones;
  logic        out_at_zero;
  logic        out_at_max;
  logic        out_entry_rejected;
  logic        out_char_valid;

  entry_result_t pending_results[$];
  logic [15:0]   entry_model;
  logic [1:0]    radix_model;
  int            mismatch_count = 0;
  int            send_idle_pct = 12;
  int            recv_idle_pct = 64;

  // keypad script: typed rows carry the value and rejected flag to expect
  keypad_row_t keypad_script [28] = '{
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_DIGIT,     4'd0,  1'b1, 16'd0,     1'b0},
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_DIGIT,     4'd10, 1'b1, 16'd0,     1'b1},
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_DEC,       4'd0,  1'b1, 16'd0,     1'b0},
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_DIGIT,     4'd6,  1'b1, 16'd6,     1'b0},
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_DIGIT,     4'd5,  1'b0, 16'd0,     1'b0},
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_DIGIT,     4'd5,  1'b0, 16'd0,     1'b0},
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_DIGIT,     4'd3,  1'b1, 16'd6553,  1'b0},
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_DIGIT,     4'd6,  1'b1, 16'd6553,  1'b1},
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_DIGIT,     4'd5,  1'b1, 16'd65535, 1'b0},
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_INC,       4'd15, 1'b1, 16'd65535, 1'b0},
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_DIGIT,     4'd0,  1'b1, 16'd65535, 1'b1},
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_BACKSPACE, 4'd9,  1'b1, 16'd6553,  1'b0},
    '{1'b0, rdr_pkg::RADIX_DEC, MODE_SPARE_5,            4'd15, 1'b1, 16'd6553,  1'b0},
    '{1'b0, rdr_pkg::RADIX_DEC, MODE_SPARE_7,            4'd0,  1'b1, 16'd6553,  1'b0},
    '{1'b0, rdr_pkg::RADIX_DEC, rdr_pkg::MODE_CLEAR,     4'd7,  1'b1, 16'd0,     1'b0},
    '{1'b1, rdr_pkg::RADIX_HEX, rdr_pkg::MODE_DIGIT,     4'd0,  1'b0, 16'd0,     1'b0},
    '{1'b0, rdr_pkg::RADIX_HEX, rdr_pkg::MODE_DIGIT,     4'd15, 1'b0, 16'd0,     1'b0},
    '{1'b0, rdr_pkg::RADIX_HEX, rdr_pkg::MODE_DIGIT,     4'd15, 1'b1, 16'd255,   1'b0},
    '{1'b0, rdr_pkg::RADIX_HEX, rdr_pkg::MODE_INC,       4'd0,  1'b1, 16'd256,   1'b0},
    '{1'b0, rdr_pkg::RADIX_HEX, rdr_pkg::MODE_DEC,       4'd0,  1'b1, 16'd255,   1'b0},
    '{1'b1, rdr_pkg::RADIX_BIN, rdr_pkg::MODE_DIGIT,     4'd0,  1'b0, 16'd0,     1'b0},
    '{1'b0, rdr_pkg::RADIX_BIN, rdr_pkg::MODE_DIGIT,     4'd2,  1'b1, 16'd255,   1'b1},
    '{1'b0, rdr_pkg::RADIX_BIN, rdr_pkg::MODE_DIGIT,     4'd1,  1'b0, 16'd0,     1'b0},
    '{1'b0, rdr_pkg::RADIX_BIN, rdr_pkg::MODE_BACKSPACE, 4'd0,  1'b1, 16'd255,   1'b0},
    '{1'b1, rdr_pkg::RADIX_OCT, rdr_pkg::MODE_DIGIT,     4'd0,  1'b0, 16'd0,     1'b0},
    '{1'b0, rdr_pkg::RADIX_OCT, rdr_pkg::MODE_DIGIT,     4'd8,  1'b1, 16'd255,   1'b1},
    '{1'b0, rdr_pkg::RADIX_OCT, rdr_pkg::MODE_DIGIT,     4'd7,  1'b0, 16'd0,     1'b0},
    '{1'b0, rdr_pkg::RADIX_OCT, rdr_pkg::MODE_BACKSPACE, 4'd0,  1'b1, 16'd255,   1'b0}
  };

  radix_digit_entry_register_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_digit           (in_digit),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_current_value  (out_current_value),
    .out_ten_thousands  (out_ten_thousands),
    .out_thousands      (out_thousands),
    .out_hundreds       (out_hundreds),
    .out_tens           (out_tens),
    .out_ones           (out_ones),
    .out_at_zero        (out_at_zero),
    .out_at_max         (out_at_max),
    .out_entry_rejected (out_entry_rejected),
    .out_char_valid     (out_char_valid)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned radix_of(input logic [1:0] sel);
    case (sel)
      rdr_pkg::RADIX_HEX: return 16;
      rdr_pkg::RADIX_DEC: return 10;
      rdr_pkg::RADIX_OCT: return 8;
      rdr_pkg::RADIX_BIN: return 2;
      default:            return 10;
    endcase
  endfunction

  function automatic entry_result_t result_of(input logic [15:0] v, input logic rej);
    entry_result_t r;
    int unsigned   n;
    n = 32'(v);
    r.value                = v;
    r.digits.ten_thousands = 3'(n / 10000);
    r.digits.thousands     = 4'((n / 1000) % 10);
    r.digits.hundreds      = 4'((n / 100) % 10);
    r.digits.tens          = 4'((n / 10) % 10);
    r.digits.ones          = 4'(n % 10);
    r.at_zero              = (v == '0);
    r.at_max               = (v == rdr_pkg::VALUE_MAX);
    r.rejected             = rej;
    r.char_valid           = (v < rdr_pkg::CHAR_LIMIT);
    return r;
  endfunction

  // next entry value for one keypad operation; updates entry_model
  function automatic entry_result_t apply_keypad_op(input logic [2:0] mode,
                                                    input logic [3:0] digit);
    int unsigned radix;
    int unsigned v;
    int unsigned shifted;
    logic        rej;
    radix = radix_of(radix_model);
    v     = 32'(entry_model);
    rej   = 1'b0;
    case (mode)
      rdr_pkg::MODE_DIGIT: begin
        if (32'(digit) >= radix) begin
          rej = 1'b1;
        end else begin
          shifted = v * radix + 32'(digit);
          if (shifted > 32'(rdr_pkg::VALUE_MAX)) rej = 1'b1;
          else v = shifted;
        end
      end
      rdr_pkg::MODE_CLEAR:     v = 0;
      rdr_pkg::MODE_BACKSPACE: v = v / radix;
      rdr_pkg::MODE_INC:       if (v != 32'(rdr_pkg::VALUE_MAX)) v = v + 1;
      rdr_pkg::MODE_DEC:       if (v != 0) v = v - 1;
      default: ;
    endcase
    entry_model = v[15:0];
    return result_of(v[15:0], rej);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic send_keypad(input logic [2:0] mode, input logic [3:0] digit,
                             input bit typed, input logic [15:0] tval, input logic trej);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
    in_mode  = mode;
    in_digit = digit;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      entry_model = tval;
      pending_results.push_back(result_of(tval, trej));
    end else begin
      pending_results.push_back(apply_keypad_op(mode, digit));
    end
  endtask

  // hold the sender off until every result has been taken
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_radix(input logic [1:0] sel);
    drain_results();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = sel;
    radix_model = sel;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // receiver back-pressure
  initial begin
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    entry_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result transfer with nothing pending, value %0d",
                                out_current_value));
      end else begin
        want = pending_results.pop_front();
        check_field("current_value", 32'(out_current_value), 32'(want.value));
        check_field("ten_thousands", 32'(out_ten_thousands),
                    32'(want.digits.ten_thousands));
        check_field("thousands", 32'(out_thousands), 32'(want.digits.thousands));
        check_field("hundreds", 32'(out_hundreds), 32'(want.digits.hundreds));
        check_field("tens", 32'(out_tens), 32'(want.digits.tens));
        check_field("ones", 32'(out_ones), 32'(want.digits.ones));
        check_field("at_zero", 32'(out_at_zero), 32'(want.at_zero));
        check_field("at_max", 32'(out_at_max), 32'(want.at_max));
        check_field("entry_rejected", 32'(out_entry_rejected), 32'(want.rejected));
        check_field("char_valid", 32'(out_char_valid), 32'(want.char_valid));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** radix_digit_entry_register_unit: FAILED **");
    $finish;
  end

  initial begin
    int unsigned radix;
    int          next_cfg;
    int          pick;
    logic [2:0]  mode;
    logic [3:0]  digit;

    entry_model = '0;
    radix_model = rdr_pkg::RADIX_DEC;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (keypad_script[i]) begin
      if (keypad_script[i].cfg_row) begin
        write_radix(keypad_script[i].radix);
      end else begin
        send_keypad(keypad_script[i].mode, keypad_script[i].digit, keypad_script[i].typed,
                    keypad_script[i].value, keypad_script[i].rejected);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12; recv_idle_pct = 64; write_radix(rdr_pkg::RADIX_HEX);
        end
        1: begin
          send_idle_pct = 64; recv_idle_pct = 12; write_radix(rdr_pkg::RADIX_BIN);
        end
        default: begin
          send_idle_pct = 0; recv_idle_pct = 0; write_radix(rdr_pkg::RADIX_DEC);
        end
      endcase
      next_cfg = $urandom_range(40, 120);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == next_cfg) begin
          write_radix(2'($urandom_range(0, 3)));
          next_cfg = n + $urandom_range(40, 120);
        end else if ($urandom_range(0, 99) == 0) begin
          drain_results();
        end
        radix = radix_of(radix_model);
        pick  = $urandom_range(0, 99);
        digit = 4'($urandom_range(0, 15));
        if (pick < 55) begin
          mode = rdr_pkg::MODE_DIGIT;
          // mostly legal digits, heavy on the top digit to reach the upper limit
          if ($urandom_range(0, 9) == 0) digit = 4'($urandom_range(0, 15));
          else if ($urandom_range(0, 9) < 3) digit = 4'(radix - 1);
          else digit = 4'($urandom_range(0, radix - 1));
        end else if (pick < 63) begin
          mode = rdr_pkg::MODE_CLEAR;
        end else if (pick < 73) begin
          mode = rdr_pkg::MODE_BACKSPACE;
        end else if (pick < 83) begin
          mode = rdr_pkg::MODE_INC;
        end else if (pick < 93) begin
          mode = rdr_pkg::MODE_DEC;
        end else begin
          mode = 3'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
        end
        send_keypad(mode, digit, 1'b0, '0, 1'b0);
      end
    end

    drain_results();
    repeat (25) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** radix_digit_entry_register_unit: PASSED **");
    end else begin
      $display("** radix_digit_entry_register_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== radix_digit_entry_register_unit.f =====
hw/rtl/rdr_pkg.sv
hw/rtl/rdr_next_value.sv
hw/rtl/rdr_bcd_conv.sv
hw/rtl/radix_digit_entry_register_unit.sv
dv/tb_radix_digit_entry_register_unit.sv
